@@ rtl/core/pidc_pkg.sv @@
// pidc_pkg: shared constants, register index codes and width helpers
// for the pid controller with output clamp; no dependencies
package pidc_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SUM_BITS    = 48;
  localparam int SUM_LO_BITS = SUM_BITS / 2;
  localparam int SUM_HI_BITS = SUM_BITS - SUM_LO_BITS;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP    = 2'd0,
    CFG_KI    = 2'd1,
    CFG_KD    = 2'd2,
    CFG_LIMIT = 2'd3
  } cfg_idx_t;

  // width that holds every full product of a gain and an error term
  function automatic int prod_width(input int dw);
    return (2 * dw + 2 > dw + SUM_BITS) ? 2 * dw + 2 : dw + SUM_BITS;
  endfunction

endpackage

@@ rtl/core/pidc_front.sv @@
// pidc_front: error, derivative difference and saturating integral state,
// first pipeline register of the controller; depends on pidc_pkg
module pidc_front #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic signed [DATA_WIDTH-1:0]        setpoint,
  input  logic signed [DATA_WIDTH-1:0]        measured,
  input  logic                                dn_ready,
  output logic                                dn_valid,
  output logic signed [DATA_WIDTH:0]          err_o,
  output logic signed [DATA_WIDTH+1:0]        diff_o,
  output logic signed [pidc_pkg::SUM_BITS-1:0] sum_o
);
  import pidc_pkg::*;

  localparam int NSW = ((SUM_BITS > DATA_WIDTH + 1) ? SUM_BITS : DATA_WIDTH + 1) + 1;

  logic                         valid_r, valid_nxt;
  logic                         accept;
  logic signed [DATA_WIDTH:0]   err_nxt, err_r;
  logic signed [DATA_WIDTH+1:0] diff_nxt, diff_r;
  logic signed [SUM_BITS-1:0]   sum_nxt, sum_r;
  logic signed [SUM_BITS-1:0]   error_sum_r;
  logic signed [DATA_WIDTH:0]   last_error_r;
  logic signed [NSW-1:0]        ns_wide;
  logic                         ns_ovf;

  always_comb begin
    err_nxt  = $signed({setpoint[DATA_WIDTH-1], setpoint})
             - $signed({measured[DATA_WIDTH-1], measured});
    diff_nxt = $signed({err_nxt[DATA_WIDTH], err_nxt})
             - $signed({last_error_r[DATA_WIDTH], last_error_r});
    ns_wide  = NSW'(error_sum_r) + NSW'(err_nxt);
    ns_ovf   = !((&ns_wide[NSW-1:SUM_BITS-1]) || !(|ns_wide[NSW-1:SUM_BITS-1]));
    if (ns_ovf) begin
      sum_nxt = ns_wide[NSW-1] ? $signed({1'b1, {(SUM_BITS-1){1'b0}}})
                               : $signed({1'b0, {(SUM_BITS-1){1'b1}}});
    end else begin
      sum_nxt = ns_wide[SUM_BITS-1:0];
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign accept    = up_valid && up_ready;
  assign valid_nxt = accept || (valid_r && !dn_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        error_sum_r  <= sum_nxt;
        last_error_r <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r  <= err_nxt;
      diff_r <= diff_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign err_o    = err_r;
  assign diff_o   = diff_r;
  assign sum_o    = sum_r;

  a_last_error_tracks : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> last_error_r == $past(err_nxt))
    else $error("previous error not updated on transaction");

  a_sum_holds_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(error_sum_r) && $stable(last_error_r))
    else $error("controller state moved without a transaction");

  a_payload_holds : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !dn_ready |=> $stable(err_r) && $stable(diff_r) && $stable(sum_r))
    else $error("stalled transaction changed");

endmodule

@@ rtl/core/pidc_mult.sv @@
// pidc_mult: gain products in two registered stages, partial products
// first, then scaled terms; depends on pidc_pkg
module pidc_mult #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic signed [DATA_WIDTH-1:0]                      kp,
  input  logic signed [DATA_WIDTH-1:0]                      ki,
  input  logic signed [DATA_WIDTH-1:0]                      kd,
  input  logic                                              up_valid,
  output logic                                              up_ready,
  input  logic signed [DATA_WIDTH:0]                        err_i,
  input  logic signed [DATA_WIDTH+1:0]                      diff_i,
  input  logic signed [pidc_pkg::SUM_BITS-1:0]              sum_i,
  input  logic                                              dn_ready,
  output logic                                              dn_valid,
  output logic signed [pidc_pkg::prod_width(DATA_WIDTH)-1:0] term_p_o,
  output logic signed [pidc_pkg::prod_width(DATA_WIDTH)-1:0] term_i_o,
  output logic signed [pidc_pkg::prod_width(DATA_WIDTH)-1:0] term_d_o
);
  import pidc_pkg::*;

  localparam int PW  = prod_width(DATA_WIDTH);
  localparam int PPW = 2 * DATA_WIDTH + 1;
  localparam int PDW = 2 * DATA_WIDTH + 2;
  localparam int PLW = DATA_WIDTH + SUM_LO_BITS + 1;
  localparam int PHW = DATA_WIDTH + SUM_HI_BITS;

  // stage a: partial products
  logic                  a_valid_r, a_valid_nxt, a_ready, a_load;
  logic signed [PPW-1:0] pp_p_nxt, pp_p_r;
  logic signed [PDW-1:0] pp_d_nxt, pp_d_r;
  logic signed [PLW-1:0] pp_il_nxt, pp_il_r;
  logic signed [PHW-1:0] pp_ih_nxt, pp_ih_r;
  logic signed [SUM_LO_BITS:0]   sum_lo;
  logic signed [SUM_HI_BITS-1:0] sum_hi;

  // stage b: scaled terms
  logic                 b_valid_r, b_valid_nxt, b_ready, b_load;
  logic signed [PW-1:0] ki_full;
  logic signed [PW-1:0] t_p_nxt, t_i_nxt, t_d_nxt;
  logic signed [PW-1:0] t_p_r, t_i_r, t_d_r;

  assign sum_lo = $signed({1'b0, sum_i[SUM_LO_BITS-1:0]});
  assign sum_hi = sum_i[SUM_BITS-1:SUM_LO_BITS];

  always_comb begin
    pp_p_nxt  = PPW'(kp) * PPW'(err_i);
    pp_d_nxt  = PDW'(kd) * PDW'(diff_i);
    pp_il_nxt = PLW'(ki) * PLW'(sum_lo);
    pp_ih_nxt = PHW'(ki) * PHW'(sum_hi);
  end

  always_comb begin
    ki_full = (PW'(pp_ih_r) <<< SUM_LO_BITS) + PW'(pp_il_r);
    t_p_nxt = PW'(pp_p_r) >>> FRAC_BITS;
    t_i_nxt = ki_full >>> FRAC_BITS;
    t_d_nxt = PW'(pp_d_r) >>> FRAC_BITS;
  end

  assign b_ready     = !b_valid_r || dn_ready;
  assign a_ready     = !a_valid_r || b_ready;
  assign up_ready    = a_ready;
  assign a_load      = up_valid && a_ready;
  assign b_load      = a_valid_r && b_ready;
  assign a_valid_nxt = a_load || (a_valid_r && !b_ready);
  assign b_valid_nxt = b_load || (b_valid_r && !dn_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      pp_p_r  <= pp_p_nxt;
      pp_d_r  <= pp_d_nxt;
      pp_il_r <= pp_il_nxt;
      pp_ih_r <= pp_ih_nxt;
    end
    if (b_load) begin
      t_p_r <= t_p_nxt;
      t_i_r <= t_i_nxt;
      t_d_r <= t_d_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign term_p_o = t_p_r;
  assign term_i_o = t_i_r;
  assign term_d_o = t_d_r;

endmodule

@@ rtl/core/pidc_clamp.sv @@
// pidc_clamp: sum of the three scaled terms, symmetric clamp and the
// output register; depends on pidc_pkg
module pidc_clamp #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic [DATA_WIDTH-2:0]                             limit,
  input  logic                                              up_valid,
  output logic                                              up_ready,
  input  logic signed [pidc_pkg::prod_width(DATA_WIDTH)-1:0] term_p_i,
  input  logic signed [pidc_pkg::prod_width(DATA_WIDTH)-1:0] term_i_i,
  input  logic signed [pidc_pkg::prod_width(DATA_WIDTH)-1:0] term_d_i,
  input  logic                                              dn_stall,
  output logic                                              dn_valid,
  output logic signed [DATA_WIDTH-1:0]                      drive,
  output logic                                              clamped
);
  import pidc_pkg::*;

  localparam int PW = prod_width(DATA_WIDTH);
  localparam int RW = PW + 2;

  logic                 c_valid_r, c_valid_nxt, c_ready, c_load;
  logic signed [RW-1:0] raw_nxt, raw_r;

  logic                          d_valid_r, d_valid_nxt, d_ready, d_load;
  logic signed [RW-1:0]          hi_lim, lo_lim;
  logic signed [DATA_WIDTH-1:0]  lim_ext;
  logic signed [DATA_WIDTH-1:0]  drive_nxt, drive_r;
  logic                          clamped_nxt, clamped_r;

  assign raw_nxt = RW'(term_p_i) + RW'(term_i_i) + RW'(term_d_i);

  always_comb begin
    lim_ext = $signed({1'b0, limit});
    hi_lim  = RW'(lim_ext);
    lo_lim  = -hi_lim;
    priority if (raw_r > hi_lim) begin
      drive_nxt   = lim_ext;
      clamped_nxt = 1'b1;
    end else if (raw_r < lo_lim) begin
      drive_nxt   = -lim_ext;
      clamped_nxt = 1'b1;
    end else begin
      drive_nxt   = raw_r[DATA_WIDTH-1:0];
      clamped_nxt = 1'b0;
    end
  end

  assign d_ready     = !d_valid_r || !dn_stall;
  assign c_ready     = !c_valid_r || d_ready;
  assign up_ready    = c_ready;
  assign c_load      = up_valid && c_ready;
  assign d_load      = c_valid_r && d_ready;
  assign c_valid_nxt = c_load || (c_valid_r && !d_ready);
  assign d_valid_nxt = d_load || (d_valid_r && dn_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      c_valid_r <= c_valid_nxt;
      d_valid_r <= d_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      raw_r <= raw_nxt;
    end
    if (d_load) begin
      drive_r   <= drive_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign dn_valid = d_valid_r;
  assign drive    = drive_r;
  assign clamped  = clamped_r;

  a_clamp_at_limit : assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r && clamped_r |-> drive_r == lim_ext || drive_r == -lim_ext)
    else $error("clamped drive is not at the limit");

  a_unclamped_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r && !clamped_r |-> drive_r <= lim_ext && drive_r >= -lim_ext)
    else $error("unclamped drive outside the limit");

  a_in_range_not_flagged : assert property (@(posedge clk) disable iff (!rst_n)
    d_load && raw_r <= hi_lim && raw_r >= lo_lim
      |=> !clamped_r && drive_r == $past(raw_r[DATA_WIDTH-1:0]))
    else $error("in-range drive flagged as clamped");

endmodule

@@ rtl/core/pid_controller_with_output_clamp_unit.sv @@
// pid_controller_with_output_clamp_unit: top level, configuration registers
// and the five-stage controller pipeline; depends on pidc_pkg, pidc_front,
// pidc_mult and pidc_clamp
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   in_setpoint, in_measured
//   out      source     out_valid/out_stall out_drive, out_clamped
//   cfg      sink       cfg_we              cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall is low; out_valid rises
// once the input has passed the front, two multiplier stages, sum and clamp register
// the integral and previous error registers update in the front stage, so
// back-to-back transactions see each other's state at once
// stages collapse bubbles; in_stall rises only when all five stages hold data
// synchronous active-low reset clears the gains, limit, state and valids
module pid_controller_with_output_clamp_unit #(
  parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [DATA_WIDTH-1:0]      in_setpoint,
  input  logic signed [DATA_WIDTH-1:0]      in_measured,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [DATA_WIDTH-1:0]      out_drive,
  output logic                              out_clamped,
  input  logic                              cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [DATA_WIDTH-1:0]             cfg_data
);
  import pidc_pkg::*;

  localparam int PW = prod_width(DATA_WIDTH);

  logic signed [DATA_WIDTH-1:0] kp_r, ki_r, kd_r;
  logic [DATA_WIDTH-2:0]        limit_r;

  logic                         front_ready, front_valid;
  logic signed [DATA_WIDTH:0]   err;
  logic signed [DATA_WIDTH+1:0] diff;
  logic signed [SUM_BITS-1:0]   sum;

  logic                 mult_ready, mult_valid;
  logic signed [PW-1:0] term_p, term_i, term_d;

  logic clamp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      limit_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KP:    kp_r    <= cfg_data;
        CFG_KI:    ki_r    <= cfg_data;
        CFG_KD:    kd_r    <= cfg_data;
        CFG_LIMIT: limit_r <= cfg_data[DATA_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  pidc_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .setpoint (in_setpoint),
    .measured (in_measured),
    .dn_ready (mult_ready),
    .dn_valid (front_valid),
    .err_o    (err),
    .diff_o   (diff),
    .sum_o    (sum)
  );

  pidc_mult #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .kp       (kp_r),
    .ki       (ki_r),
    .kd       (kd_r),
    .up_valid (front_valid),
    .up_ready (mult_ready),
    .err_i    (err),
    .diff_i   (diff),
    .sum_i    (sum),
    .dn_ready (clamp_ready),
    .dn_valid (mult_valid),
    .term_p_o (term_p),
    .term_i_o (term_i),
    .term_d_o (term_d)
  );

  pidc_clamp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_clamp (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (limit_r),
    .up_valid (mult_valid),
    .up_ready (clamp_ready),
    .term_p_i (term_p),
    .term_i_i (term_i),
    .term_d_i (term_d),
    .dn_stall (out_stall),
    .dn_valid (out_valid),
    .drive    (out_drive),
    .clamped  (out_clamped)
  );

  assign in_stall = !front_ready;

endmodule
